// ===== hdl/pds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared word types and controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int FIELD_W = 17;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               last;
  } item_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } result_word_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic ovf;
  } pds_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
  } pds_status_t;

endpackage

// ===== hdl/postman_digit_sorter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postman_digit_sorter_top
// Collects a set of unsigned values and returns them in ascending order.
//
// Input channel item/item_valid/item_ready: one value per word, last = 1
// closes the set. Up to MAX_ITEMS values are kept; further loads are
// dropped and reported by the overflow bit of every result of that set.
// The cells insert each accepted value in sorted position.
// After the last word, item_ready stays low while the set drains on
// result/result_valid/result_ready, one word per cycle, last_out on the
// final one. The last word moves the state register to DRAIN, and the
// first pop there writes the result register.
// A stalled receiver holds the result register and pauses the drain.
// The next set may load while the final result still waits.
// Reset (rst, synchronous) empties the cells and clears overflow.
// ----------------------------------------------------------------------------
module postman_digit_sorter_top #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  pds_pkg::item_word_t   item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output pds_pkg::result_word_t result
);
  import pds_pkg::*;

  pds_cmd_t    cmd;
  pds_status_t status;

  pds_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  pds_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

// ===== hdl/pds_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_datapath
// Row of sorting cells kept in ascending order on insert, shifted toward
// cell 0 on pop, plus the result word register.
// ----------------------------------------------------------------------------
module pds_datapath #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pds_pkg::item_word_t  item,
  input  pds_pkg::pds_cmd_t    cmd,
  output pds_pkg::pds_status_t status,
  output pds_pkg::result_word_t result
);
  import pds_pkg::*;

  logic [VALUE_BITS-1:0] cells     [MAX_ITEMS];
  logic [VALUE_BITS-1:0] ins_val   [MAX_ITEMS];
  logic [VALUE_BITS-1:0] pop_val   [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]  vld;
  logic [MAX_ITEMS-1:0]  gt;
  logic [VALUE_BITS-1:0] v;

  assign v = VALUE_BITS'(item.value);

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    assign gt[g] = !vld[g] || (cells[g] > v);
    if (g == 0) begin : g_head
      assign ins_val[g] = gt[g] ? v : cells[g];
    end else begin : g_body
      assign ins_val[g] = gt[g] ? (gt[g-1] ? cells[g-1] : v) : cells[g];
    end
    if (g == MAX_ITEMS - 1) begin : g_tail
      assign pop_val[g] = cells[g];
    end else begin : g_mid
      assign pop_val[g] = cells[g+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.insert) begin
      vld <= {vld[MAX_ITEMS-2:0], 1'b1};
    end else if (cmd.pop) begin
      vld <= {1'b0, vld[MAX_ITEMS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (cmd.insert) begin
        cells[i] <= ins_val[i];
      end else if (cmd.pop) begin
        cells[i] <= pop_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      result.sorted_value <= FIELD_W'(cells[0]);
      result.last_out     <= !vld[1];
      result.overflow     <= cmd.ovf;
    end
  end

  assign status.full     = vld[MAX_ITEMS-1];
  assign status.empty    = !vld[0];
  assign status.one_left = !vld[1];

endmodule

// ===== hdl/pds_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_ctrl
// Load/drain sequencer: accepts words until the last flag, then pops the
// cell row into the result register, tracking dropped loads.
// ----------------------------------------------------------------------------
module pds_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  pds_pkg::item_word_t  item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output pds_pkg::pds_cmd_t    cmd,
  input  pds_pkg::pds_status_t status
);
  import pds_pkg::*;

  typedef enum logic {
    LOAD,
    DRAIN
  } state_t;

  state_t state;
  logic   ovf;
  logic   accept;

  assign item_ready = (state == LOAD);
  assign accept     = item_valid && item_ready;

  assign cmd.insert = accept && !status.full;
  assign cmd.pop    = (state == DRAIN) && (!result_valid || result_ready) && !status.empty;
  assign cmd.ovf    = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.pop) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        LOAD: begin
          if (accept) begin
            if (status.full) begin
              ovf <= 1'b1;
            end
            if (item.last) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          if (cmd.pop && status.one_left) begin
            state <= LOAD;
            ovf   <= 1'b0;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_hold_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && item.last) |=> !item_ready)
    else $error("word accepted while draining");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == DRAIN) |-> !status.empty)
    else $error("drain with empty cell row");

  a_ovf_on_full: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> $past(status.full))
    else $error("overflow set without full row");

  a_end_of_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop && status.one_left) |=> (state == LOAD) && !ovf)
    else $error("set did not close after final pop");

endmodule

// ===== sim/postman_digit_sorter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postman_digit_sorter_top_tb
// Self-checking bench for the ascending sorter. Loads sets of values, from a
// short table of hand-picked sets to random sets up to two past capacity,
// and compares every result word against a software sort of the held set.
// Both handshakes idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module postman_digit_sorter_top_tb;
  import pds_pkg::*;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 17;
  localparam int STIM_ROWS  = 20;
  localparam int RAND_ITEMS = 150;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               last;
    logic               typed;
    logic [FIELD_W-1:0] sorted_value;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid;
  logic         item_ready;
  item_word_t   item;
  logic         result_valid;
  logic         result_ready;
  result_word_t result;

  logic [FIELD_W-1:0] held_vals [MAX_ITEMS];
  int                 held_n = 0;
  bit                 lost_load = 1'b0;
  result_word_t       sorted_due [$];
  result_word_t       due_word;
  int                 fail_count = 0;
  int                 cycles = 0;
  bit                 quiet = 1'b0;

  postman_digit_sorter_top #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // keeps the held set in ascending order; a closing word queues the whole set
  function automatic void predict_sort(input item_word_t w);
    logic [FIELD_W-1:0] v;
    int                 pos;
    result_word_t       r;
    v = w.value & FIELD_W'((64'd1 << VALUE_BITS) - 1);
    if (held_n < MAX_ITEMS) begin
      pos = held_n;
      while (pos > 0 && held_vals[pos-1] > v) begin
        held_vals[pos] = held_vals[pos-1];
        pos--;
      end
      held_vals[pos] = v;
      held_n++;
    end else begin
      lost_load = 1'b1;
    end
    if (w.last) begin
      for (int k = 0; k < held_n; k++) begin
        r.sorted_value = held_vals[k];
        r.last_out     = (k == held_n - 1);
        r.overflow     = lost_load;
        sorted_due.push_back(r);
      end
      held_n    = 0;
      lost_load = 1'b0;
    end
  endfunction

  task automatic load_word(input item_word_t w, input bit typed,
                           input logic [FIELD_W-1:0] typed_value);
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_sort(w);
    if (typed)
      sorted_due[sorted_due.size()-1] = '{typed_value, 1'b1, 1'b0};
    if (!quiet && $urandom_range(0, 2) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  initial begin
    stim_row_t  stim_rows [STIM_ROWS];
    item_word_t w;
    int         set_idx;
    int         set_len;
    int         rand_sent;
    int         pick;

    item_valid = 1'b0;
    item       = '0;

    // one-value sets at the extremes and in alternating bit patterns, then small sets, some with duplicates
    stim_rows[0]  = '{17'h00000, 1'b1, 1'b1, 17'h00000};
    stim_rows[1]  = '{17'h1FFFF, 1'b1, 1'b1, 17'h1FFFF};
    stim_rows[2]  = '{17'h15555, 1'b1, 1'b1, 17'h15555};
    stim_rows[3]  = '{17'h0AAAA, 1'b1, 1'b1, 17'h0AAAA};
    stim_rows[4]  = '{17'h00009, 1'b0, 1'b0, 17'h00000};
    stim_rows[5]  = '{17'h1FFFF, 1'b0, 1'b0, 17'h00000};
    stim_rows[6]  = '{17'h00003, 1'b0, 1'b0, 17'h00000};
    stim_rows[7]  = '{17'h00009, 1'b0, 1'b0, 17'h00000};
    stim_rows[8]  = '{17'h00000, 1'b0, 1'b0, 17'h00000};
    stim_rows[9]  = '{17'h10000, 1'b0, 1'b0, 17'h00000};
    stim_rows[10] = '{17'h00003, 1'b1, 1'b0, 17'h00000};
    stim_rows[11] = '{17'h00001, 1'b0, 1'b0, 17'h00000};
    stim_rows[12] = '{17'h00002, 1'b0, 1'b0, 17'h00000};
    stim_rows[13] = '{17'h00003, 1'b1, 1'b0, 17'h00000};
    stim_rows[14] = '{17'h1FFFF, 1'b0, 1'b0, 17'h00000};
    stim_rows[15] = '{17'h1FFFE, 1'b0, 1'b0, 17'h00000};
    stim_rows[16] = '{17'h00001, 1'b0, 1'b0, 17'h00000};
    stim_rows[17] = '{17'h00000, 1'b1, 1'b0, 17'h00000};
    stim_rows[18] = '{17'h00007, 1'b0, 1'b0, 17'h00000};
    stim_rows[19] = '{17'h00007, 1'b1, 1'b0, 17'h00000};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < STIM_ROWS; i++) begin
      w.value = stim_rows[i].value;
      w.last  = stim_rows[i].last;
      load_word(w, stim_rows[i].typed, stim_rows[i].sorted_value);
    end

    // random sets; set 3 fills the store exactly, set 7 drops two loads
    // including its closing word
    set_idx   = 0;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (set_idx == 3)
        set_len = MAX_ITEMS;
      else if (set_idx == 7)
        set_len = MAX_ITEMS + 2;
      else
        set_len = $urandom_range(1, 8);
      for (int k = 0; k < set_len; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          w.value = '0;
        else if (pick == 1)
          w.value = '1;
        else if (pick < 4)
          w.value = FIELD_W'($urandom_range(0, 15));
        else
          w.value = FIELD_W'($urandom);
        w.last = (k == set_len - 1);
        load_word(w, 1'b0, '0);
        rand_sent++;
        if (rand_sent > RAND_ITEMS - 25)
          quiet = 1'b1;
      end
      set_idx++;
    end
    item_valid <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: result word with nothing due: expected none, actual %h",
                 $time, result);
        fail_count++;
      end else begin
        due_word = sorted_due.pop_front();
        if (result.sorted_value !== due_word.sorted_value) begin
          $display("%0t: sorted_value expected %h actual %h",
                   $time, due_word.sorted_value, result.sorted_value);
          fail_count++;
        end
        if (result.last_out !== due_word.last_out) begin
          $display("%0t: last_out expected %b actual %b",
                   $time, due_word.last_out, result.last_out);
          fail_count++;
        end
        if (result.overflow !== due_word.overflow) begin
          $display("%0t: overflow expected %b actual %b",
                   $time, due_word.overflow, result.overflow);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d result words still due", $time, sorted_due.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule
